### rtl/core/cdrb_pkg.sv
// Shared types, constants and byte tables for the captive DNS response builder.
package cdrb_pkg;

   localparam int MAX_PACKET = 512;
   localparam int POS_W = $clog2(MAX_PACKET + 1);
   localparam int ANSWER_LEN = 16;
   localparam int ANS_IDX_W = $clog2(ANSWER_LEN);
   localparam int ADDR_W = 32;
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam logic [7:0] FLAGS_HI = 8'h84;
   localparam logic [7:0] FLAGS_LO = 8'h80;
   localparam logic [7:0] COMPRESS_MASK = 8'hC0;
   localparam logic [7:0] NAME_PTR_HI = 8'hC0;
   localparam logic [7:0] NAME_PTR_LO = 8'h0C;
   localparam logic [7:0] RDLENGTH_LO = 8'h04;
   localparam logic [ADDR_W-1:0] ADDR_RESET = 32'hC0A8_0401;

   typedef struct packed {
      logic [7:0] query_byte;
      logic       query_last;
   } query_type;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       reply_last;
      logic       reply_drop;
   } reply_type;

   typedef enum logic [1:0] {
      TERM_NONE   = 2'd0,
      TERM_ANSWER = 2'd1,
      TERM_DROP   = 2'd2
   } term_type;

   // At most one command per request: an optional echoed byte, then an optional ending.
   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_byte;
      term_type   term;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
   } cmdq_status_type;

   // Header rewrite: flags become 0x84,0x80, the question count is echoed and the other counts become 1/0/0.
   function automatic logic [7:0] header_byte(input logic [3:0] pos, input logic [7:0] b);
      logic [7:0] r;
      unique case (pos)
         4'd2:    r = FLAGS_HI;
         4'd3:    r = FLAGS_LO;
         4'd7:    r = 8'h01;
         4'd0, 4'd1, 4'd4, 4'd5: r = b;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // Bytes of the appended A record.
   function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                              input logic [ADDR_W-1:0] addr);
      logic [7:0] r;
      unique case (idx)
         4'd0:    r = NAME_PTR_HI;
         4'd1:    r = NAME_PTR_LO;
         4'd3:    r = 8'h01;
         4'd5:    r = 8'h01;
         4'd11:   r = RDLENGTH_LO;
         4'd12:   r = addr[31:24];
         4'd13:   r = addr[23:16];
         4'd14:   r = addr[15:8];
         4'd15:   r = addr[7:0];
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/cdrb_front.sv
// Query parser: walks header and question, and emits at most one command per request.
module cdrb_front import cdrb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  query_type query,
   output logic      cmd_push,
   output cmd_type   cmd
);

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_LEN    = 5'b00010,
      PH_BODY   = 5'b00100,
      PH_TC     = 5'b01000,
      PH_TRAIL  = 5'b10000
   } phase_type;

   logic [POS_W-1:0] pos_ff, pos_in;
   phase_type        phase_ff, phase_in;
   logic [5:0]       label_ff, label_in;
   logic [2:0]       tc_ff, tc_in;
   logic             mal_ff, mal_in;

   logic [5:0]       label_dec;
   logic [2:0]       tc_next;
   logic [POS_W:0]   end_pos;
   logic             room_bad;
   logic [7:0]       b;

   assign b = query.query_byte;
   assign label_dec = (label_ff != 6'd0) ? label_ff - 6'd1 : 6'd0;
   assign tc_next = tc_ff + 3'd1;
   assign end_pos = {1'b0, pos_ff} + (POS_W + 1)'(ANSWER_LEN + 1);
   assign room_bad = end_pos > (POS_W + 1)'(MAX_PACKET);

   always_comb begin
      pos_in = pos_ff;
      phase_in = phase_ff;
      label_in = label_ff;
      tc_in = tc_ff;
      mal_in = mal_ff;
      cmd.echo_valid = 1'b0;
      cmd.echo_byte = b;
      cmd.term = TERM_NONE;
      if (!mal_ff) begin
         if (pos_ff >= POS_W'(MAX_PACKET)) begin
            mal_in = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  cmd.echo_valid = 1'b1;
                  cmd.echo_byte = header_byte(pos_ff[3:0], b);
                  if (pos_ff == POS_W'(11)) phase_in = PH_LEN;
               end
               PH_LEN: begin
                  if (b == 8'h00) begin
                     cmd.echo_valid = 1'b1;
                     tc_in = 3'd0;
                     phase_in = PH_TC;
                  end else if ((b & COMPRESS_MASK) != 8'h00) begin
                     mal_in = 1'b1;
                  end else begin
                     cmd.echo_valid = 1'b1;
                     label_in = b[5:0];
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY: begin
                  cmd.echo_valid = 1'b1;
                  label_in = label_dec;
                  if (label_dec == 6'd0) phase_in = PH_LEN;
               end
               PH_TC: begin
                  tc_in = tc_next;
                  if (tc_next >= 3'd4) begin
                     // The last class byte must leave room for the answer record.
                     if (room_bad) begin
                        mal_in = 1'b1;
                     end else begin
                        cmd.echo_valid = 1'b1;
                        phase_in = PH_TRAIL;
                     end
                  end else begin
                     cmd.echo_valid = 1'b1;
                  end
               end
               PH_TRAIL: begin
               end
               default: begin
               end
            endcase
            pos_in = pos_ff + POS_W'(1);
         end
      end
      if (query.query_last) begin
         cmd.term = (!mal_in && phase_in == PH_TRAIL) ? TERM_ANSWER : TERM_DROP;
         pos_in = '0;
         phase_in = PH_HEADER;
         label_in = 6'd0;
         tc_in = 3'd0;
         mal_in = 1'b0;
      end
   end

   assign cmd_push = accept && (cmd.echo_valid || query.query_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         phase_ff <= PH_HEADER;
         label_ff <= 6'd0;
         tc_ff <= 3'd0;
         mal_ff <= 1'b0;
      end else if (accept) begin
         pos_ff <= pos_in;
         phase_ff <= phase_in;
         label_ff <= label_in;
         tc_ff <= tc_in;
         mal_ff <= mal_in;
      end
   end

endmodule

### rtl/core/cdrb_cmd_fifo.sv
// Short command queue between the parser and the reply emitter.
module cdrb_cmd_fifo import cdrb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cmd_type         push_cmd,
   input  logic            pop,
   output cmd_type         head_cmd,
   output cmdq_status_type status
);

   cmd_type              mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + CMD_CNT_W'(push) - CMD_CNT_W'(pop);
   end

   assign head_cmd = mem_ff[rd_ptr_ff];
   assign status.full = count_ff == CMD_CNT_W'(CMD_DEPTH);
   assign status.valid = count_ff != '0;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/cdrb_back.sv
// Reply emitter: plays out commands as reply items through an output register.
module cdrb_back import cdrb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cmd_type           head_cmd,
   input  logic [ADDR_W-1:0] answer_address,
   input  logic              rsp_pop,
   output logic              cmd_pop,
   output logic              rsp_valid,
   output reply_type         rsp_item
);

   typedef enum logic [1:0] {
      B_ECHO = 2'b01,
      B_TERM = 2'b10
   } back_state_type;

   back_state_type       state_ff, state_in;
   logic [ANS_IDX_W-1:0] idx_ff, idx_in;
   logic                 out_valid_ff, out_valid_in;
   reply_type            out_item_ff;
   reply_type            item;
   logic                 emit;
   logic                 out_free;
   logic                 idx_end;

   assign out_free = !out_valid_ff || rsp_pop;
   assign idx_end = idx_ff == ANS_IDX_W'(ANSWER_LEN - 1);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      emit = 1'b0;
      cmd_pop = 1'b0;
      item = '0;
      unique case (state_ff)
         B_ECHO: begin
            // A command with no echoed byte moves on without using the output.
            if (head_valid && (out_free || !head_cmd.echo_valid)) begin
               if (head_cmd.echo_valid) begin
                  emit = 1'b1;
                  item.reply_byte = head_cmd.echo_byte;
               end
               if (head_cmd.term == TERM_NONE) begin
                  cmd_pop = 1'b1;
               end else begin
                  state_in = B_TERM;
                  idx_in = '0;
               end
            end
         end
         B_TERM: begin
            if (head_valid && out_free) begin
               emit = 1'b1;
               case (head_cmd.term)
                  TERM_ANSWER: begin
                     item.reply_byte = answer_byte(idx_ff, answer_address);
                     item.reply_last = idx_end;
                     if (idx_end) begin
                        cmd_pop = 1'b1;
                        state_in = B_ECHO;
                     end else begin
                        idx_in = idx_ff + ANS_IDX_W'(1);
                     end
                  end
                  default: begin
                     item.reply_last = 1'b1;
                     item.reply_drop = 1'b1;
                     cmd_pop = 1'b1;
                     state_in = B_ECHO;
                  end
               endcase
            end
         end
         default: begin
            state_in = B_ECHO;
         end
      endcase
      out_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item = out_item_ff;

   always_ff @(posedge clock) begin
      if (emit) out_item_ff <= item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_ECHO;
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### rtl/core/captive_dns_response_builder.sv
// Top level of the captive DNS response builder.
// The block takes a DNS query one byte per request and streams the reply:
// the rewritten header and the echoed question come out at one byte per
// cycle while the emitter is not busy with an answer and the output is
// not waiting for rsp_pop, each byte passing through the command queue
// and the output register; bytes after the question produce nothing. The
// final byte of a well-formed query adds a 16-byte A record pointing at
// answer_address; a malformed query ends in one item with reply_drop set.
// A four-entry command queue sits between the parser and the emitter, so
// requests keep flowing during an answer until the queue fills. The
// configuration register has no wait states (csr_ready is always high).
module captive_dns_response_builder import cdrb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  query_type         req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output reply_type         rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ADDR_W-1:0] csr_data
);

   logic [ADDR_W-1:0] addr_ff;
   logic              accept;
   logic              cmd_push;
   logic              cmd_pop;
   cmd_type           front_cmd;
   cmd_type           head_cmd;
   cmdq_status_type   q_status;
   logic              rsp_valid;

   assign csr_ready = 1'b1;
   assign req_full = q_status.full;
   assign accept = req_push && !q_status.full;
   assign rsp_empty = !rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= ADDR_RESET;
      end else if (csr_valid) begin
         addr_ff <= csr_data;
      end
   end

   cdrb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .query    (req_data),
      .cmd_push (cmd_push),
      .cmd      (front_cmd)
   );

   cdrb_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   cdrb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_status.valid),
      .head_cmd       (head_cmd),
      .answer_address (addr_ff),
      .rsp_pop        (rsp_pop),
      .cmd_pop        (cmd_pop),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_data)
   );

endmodule

### rtl/core/cdrb_checker.sv
// Port-level checks for the captive DNS response builder, bound to the top level.
module cdrb_checker import cdrb_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_full,
   input logic      rsp_empty,
   input logic      rsp_pop,
   input reply_type rsp_data
);

   // A drop marker always closes its reply.
   a_drop_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.reply_drop) |-> rsp_data.reply_last)
      else $error("drop item without reply_last");

   // A drop marker carries a zero byte.
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.reply_drop) |-> (rsp_data.reply_byte == 8'h00))
      else $error("drop item with nonzero byte");

   // A waiting result stays put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed before pop");

   // Reset leaves no results pending and room for a request.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("block not empty after reset");

endmodule

bind captive_dns_response_builder cdrb_checker u_checker (.*);
